FILE: design/msdc_pkg.sv
// Shared types and codes for the merge sort block with per-depth comparison counts.
package msdc_pkg;

	// Item kinds
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_READ_ELEM = 2'd1;
	localparam logic [1:0] KIND_READ_COUNT = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	// Depth counters saturate here
	localparam logic [11:0] COUNT_MAX = 12'hFFF;

	typedef struct packed {
		logic [1:0] kind;
		logic signed [31:0] value;
		logic last;
		logic [10:0] index;
	} req_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic [11:0] compare_count;
		logic [1:0] status;
	} rsp_t;

	// Sort sequencer states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_VISIT = 6'b000010,
		ST_COPY  = 6'b000100,
		ST_MA    = 6'b001000,
		ST_MB    = 6'b010000,
		ST_MC    = 6'b100000
	} sort_state_t;

endpackage

FILE: design/msdc_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module msdc_ram #(
	parameter int W = 32,
	parameter int AW = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/merge_sort_with_depth_counts_core.sv
// Top level: load/read item handling, depth counters and the merge sort sequencer.
//
//  channel | valid     | stall     | payload           | use
//  --------+-----------+-----------+-------------------+---------------------------------
//  request | req_valid | req_stall | req  (req_t)      | load element, read element/count
//  result  | rsp_valid | rsp_stall | rsp  (rsp_t)      | one result per request item
//
// Loads and reads flow back to back while the sequencer is idle and results are not
// stalled; a result passes the request stage (with the element RAM read) and the output register.
// The load marked last starts the sort when the batch holds more than one element.
// Visit steps pop leaf segments and split the others; each merge copies its segment to
// scratch, then per merged element reads a and b on the single scratch read port and
// writes the smaller back; requests stall until the sort ends.
// Reset clears control, counters and the batch state; RAM contents are not cleared.
// A stalled result holds its register; one further item may be taken behind it.
module merge_sort_with_depth_counts_core #(
	parameter int CAPACITY = 2048,
	parameter int DEPTH_SLOTS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  msdc_pkg::req_t     req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output msdc_pkg::rsp_t     rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = $clog2($clog2(CAPACITY) + 2);
	localparam int DSW = $clog2(DEPTH_SLOTS);
	localparam int SD = 2 * $clog2(CAPACITY) + 2;
	localparam int SPW = $clog2(SD + 1);
	localparam int SIW = $clog2(SD);

	// Batch and counters
	logic [CW-1:0] count_q;
	logic batch_q;
	logic [11:0] dcnt_q [DEPTH_SLOTS];

	// Request/result pipeline
	logic v_s1, rd_s1;
	logic [1:0] status_s1;
	logic [11:0] cnt_s1;
	logic out_v_q;
	msdc_pkg::rsp_t out_q;

	// Sequencer
	msdc_pkg::sort_state_t st_q;
	logic [AW-1:0] stk_lo [SD];
	logic [AW-1:0] stk_hi [SD];
	logic [DW-1:0] stk_d [SD];
	logic stk_x [SD];
	logic [SPW-1:0] sp_q;
	logic [AW-1:0] mid_q, hi_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] t_q, a_q, b_q, k_q;
	logic cw_v_s1;
	logic [AW-1:0] cw_addr_s1;
	logic signed [31:0] va_q;

	// RAM ports
	logic e_we, e_re, s_re;
	logic [AW-1:0] e_waddr, e_raddr, s_raddr;
	logic [31:0] e_wdata, e_rdata, s_rdata;

	logic accept, mv, is_load, is_rd_e, is_rd_c;
	logic [CW-1:0] base_cnt, new_cnt;
	logic full, start;
	logic [SIW-1:0] top_i;
	logic [AW-1:0] t_lo, t_hi, t_mid;
	logic both, take_a, cnt_inc;
	logic signed [31:0] vb;

	assign req_stall = (st_q != msdc_pkg::ST_IDLE) || (v_s1 && out_v_q && rsp_stall);
	assign accept = req_valid && !req_stall;
	assign mv = v_s1 && (!out_v_q || !rsp_stall);
	assign is_load = req.kind == msdc_pkg::KIND_LOAD;
	assign is_rd_e = req.kind == msdc_pkg::KIND_READ_ELEM;
	assign is_rd_c = req.kind == msdc_pkg::KIND_READ_COUNT;

	// Load bookkeeping
	assign base_cnt = batch_q ? count_q : '0;
	assign full = 32'(base_cnt) == CAPACITY;
	assign new_cnt = full ? base_cnt : base_cnt + CW'(1);
	assign start = accept && is_load && req.last && (new_cnt > CW'(1));

	// Stack top and merge decision
	assign top_i = SIW'(sp_q - SPW'(1));
	assign t_lo = stk_lo[top_i];
	assign t_hi = stk_hi[top_i];
	assign t_mid = t_lo + ((t_hi - t_lo) >> 1);
	assign vb = s_rdata;
	assign both = (a_q <= CW'(mid_q)) && (b_q <= CW'(hi_q));
	assign take_a = (a_q <= CW'(mid_q)) && ((b_q > CW'(hi_q)) || (va_q <= vb));
	assign cnt_inc = (st_q == msdc_pkg::ST_MC) && both && (32'(d_q) < DEPTH_SLOTS);

	// Element RAM port muxing: loads/reads when idle, copy/merge while sorting
	always_comb begin
		e_we = 1'b0;
		e_waddr = AW'(base_cnt);
		e_wdata = req.value;
		e_re = 1'b0;
		e_raddr = AW'(32'(req.index));
		if (st_q == msdc_pkg::ST_MC) begin
			e_we = 1'b1;
			e_waddr = AW'(k_q);
			e_wdata = take_a ? va_q : vb;
		end else if (accept && is_load && !full) begin
			e_we = 1'b1;
		end
		if (st_q == msdc_pkg::ST_COPY) begin
			e_re = 1'b1;
			e_raddr = AW'(t_q);
		end else if (accept && is_rd_e) begin
			e_re = 1'b1;
		end
	end

	assign s_re = (st_q == msdc_pkg::ST_MA) || (st_q == msdc_pkg::ST_MB);
	assign s_raddr = (st_q == msdc_pkg::ST_MA) ? AW'(a_q) : AW'(b_q);

	msdc_ram #(.W(32), .AW(AW)) u_elem (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.re(e_re), .raddr(e_raddr), .rdata(e_rdata)
	);

	msdc_ram #(.W(32), .AW(AW)) u_scratch (
		.clk(clk), .we(cw_v_s1), .waddr(cw_addr_s1), .wdata(e_rdata),
		.re(s_re), .raddr(s_raddr), .rdata(s_rdata)
	);

	// Batch state, element count and depth counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			batch_q <= 1'b0;
			for (int i = 0; i < DEPTH_SLOTS; i++) dcnt_q[i] <= '0;
		end else begin
			if (accept && is_load) begin
				count_q <= new_cnt;
				batch_q <= !req.last;
				if (!batch_q) begin
					for (int i = 0; i < DEPTH_SLOTS; i++) dcnt_q[i] <= '0;
				end
			end
			if (cnt_inc && dcnt_q[DSW'(32'(d_q))] != msdc_pkg::COUNT_MAX) begin
				dcnt_q[DSW'(32'(d_q))] <= dcnt_q[DSW'(32'(d_q))] + 12'd1;
			end
		end
	end

	// Request stage: decide status and count; element data comes from the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (mv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= 1'b0;
			cnt_s1 <= '0;
			status_s1 <= msdc_pkg::STATUS_OK;
			if (is_load) begin
				if (full) status_s1 <= msdc_pkg::STATUS_FULL;
			end else if (is_rd_e) begin
				if (32'(req.index) < 32'(count_q)) rd_s1 <= 1'b1;
				else status_s1 <= msdc_pkg::STATUS_RANGE;
			end else if (is_rd_c) begin
				if (32'(req.index) < DEPTH_SLOTS) cnt_s1 <= dcnt_q[DSW'(32'(req.index))];
				else status_s1 <= msdc_pkg::STATUS_RANGE;
			end else begin
				status_s1 <= msdc_pkg::STATUS_RANGE;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (mv) begin
			out_v_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mv) begin
			out_q.element <= rd_s1 ? e_rdata : '0;
			out_q.compare_count <= cnt_s1;
			out_q.status <= status_s1;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp = out_q;

	// Sort sequencer: explicit segment stack, copy to scratch, then merge back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= msdc_pkg::ST_IDLE;
			sp_q <= '0;
			cw_v_s1 <= 1'b0;
		end else begin
			cw_v_s1 <= 1'b0;
			case (st_q)
				msdc_pkg::ST_IDLE: begin
					if (start) begin
						sp_q <= SPW'(1);
						st_q <= msdc_pkg::ST_VISIT;
					end
				end
				msdc_pkg::ST_VISIT: begin
					if (sp_q == '0) begin
						st_q <= msdc_pkg::ST_IDLE;
					end else if (t_lo >= t_hi) begin
						sp_q <= sp_q - SPW'(1);
					end else if (!stk_x[top_i]) begin
						sp_q <= sp_q + SPW'(2);
					end else begin
						sp_q <= sp_q - SPW'(1);
						st_q <= msdc_pkg::ST_COPY;
					end
				end
				msdc_pkg::ST_COPY: begin
					cw_v_s1 <= 1'b1;
					if (t_q == CW'(hi_q)) st_q <= msdc_pkg::ST_MA;
				end
				msdc_pkg::ST_MA: st_q <= msdc_pkg::ST_MB;
				msdc_pkg::ST_MB: st_q <= msdc_pkg::ST_MC;
				msdc_pkg::ST_MC: begin
					st_q <= (k_q == CW'(hi_q)) ? msdc_pkg::ST_VISIT : msdc_pkg::ST_MA;
				end
				default: st_q <= msdc_pkg::ST_IDLE;
			endcase
		end
	end

	// Sequencer datapath: stack entries, merge bounds and pointers
	always_ff @(posedge clk) begin
		cw_addr_s1 <= AW'(t_q);
		case (st_q)
			msdc_pkg::ST_IDLE: begin
				if (start) begin
					stk_lo[0] <= '0;
					stk_hi[0] <= AW'(new_cnt - CW'(1));
					stk_d[0] <= DW'(1);
					stk_x[0] <= 1'b0;
				end
			end
			msdc_pkg::ST_VISIT: begin
				if (sp_q != '0 && t_lo < t_hi) begin
					if (!stk_x[top_i]) begin
						stk_x[top_i] <= 1'b1;
						stk_lo[SIW'(sp_q)] <= t_mid + AW'(1);
						stk_hi[SIW'(sp_q)] <= t_hi;
						stk_d[SIW'(sp_q)] <= stk_d[top_i] + DW'(1);
						stk_x[SIW'(sp_q)] <= 1'b0;
						stk_lo[SIW'(sp_q + SPW'(1))] <= t_lo;
						stk_hi[SIW'(sp_q + SPW'(1))] <= t_mid;
						stk_d[SIW'(sp_q + SPW'(1))] <= stk_d[top_i] + DW'(1);
						stk_x[SIW'(sp_q + SPW'(1))] <= 1'b0;
					end else begin
						mid_q <= t_mid;
						hi_q <= t_hi;
						d_q <= stk_d[top_i];
						t_q <= CW'(t_lo);
						a_q <= CW'(t_lo);
						b_q <= CW'(t_mid) + CW'(1);
						k_q <= CW'(t_lo);
					end
				end
			end
			msdc_pkg::ST_COPY: t_q <= t_q + CW'(1);
			msdc_pkg::ST_MB: va_q <= s_rdata;
			msdc_pkg::ST_MC: begin
				k_q <= k_q + CW'(1);
				if (take_a) a_q <= a_q + CW'(1);
				else b_q <= b_q + CW'(1);
			end
			default: ;
		endcase
	end

endmodule
